>>> rtl/hee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hee_pkg: shared types and tables of the HTML entity escaper
// Entity kinds, queue entry layout and the entity text tables.
// ----------------------------------------------------------------------------
package hee_pkg;

  localparam int unsigned MaskW     = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QAddrW    = $clog2(QDepth);
  localparam int unsigned QCountW   = $clog2(QDepth + 1);

  localparam logic [MaskW-1:0] MaskReset = 5'd31;

  // mask bit positions
  localparam int unsigned BitAmp  = 0;
  localparam int unsigned BitQuot = 1;
  localparam int unsigned BitApos = 2;
  localparam int unsigned BitLt   = 3;
  localparam int unsigned BitGt   = 4;

  localparam logic [ByteW-1:0] ChAmp  = 8'h26;
  localparam logic [ByteW-1:0] ChQuot = 8'h22;
  localparam logic [ByteW-1:0] ChApos = 8'h27;
  localparam logic [ByteW-1:0] ChLt   = 8'h3c;
  localparam logic [ByteW-1:0] ChGt   = 8'h3e;
  localparam logic [ByteW-1:0] ChSemi = 8'h3b;
  localparam logic [ByteW-1:0] ChHash = 8'h23;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_AMP,
    KIND_QUOT,
    KIND_APOS,
    KIND_LT,
    KIND_GT
  } ent_kind_e;

  typedef struct packed {
    ent_kind_e        kind;
    logic [ByteW-1:0] raw;
  } item_t;

  // number of output bytes for one item
  function automatic logic [IdxW-1:0] entity_len(input ent_kind_e kind);
    logic [IdxW-1:0] len;
    case (kind)
      KIND_AMP:  len = 3'd5;
      KIND_QUOT: len = 3'd6;
      KIND_APOS: len = 3'd6;
      KIND_LT:   len = 3'd4;
      KIND_GT:   len = 3'd4;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  // byte at position idx of the expansion of one item
  function automatic logic [ByteW-1:0] entity_byte(input ent_kind_e kind,
                                                   input logic [IdxW-1:0] idx,
                                                   input logic [ByteW-1:0] raw);
    logic [ByteW-1:0] b;
    b = raw;
    case (kind)
      KIND_AMP: begin
        case (idx)
          3'd0:    b = ChAmp;
          3'd1:    b = 8'h61; // a
          3'd2:    b = 8'h6d; // m
          3'd3:    b = 8'h70; // p
          default: b = ChSemi;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd0:    b = ChAmp;
          3'd1:    b = 8'h71; // q
          3'd2:    b = 8'h75; // u
          3'd3:    b = 8'h6f; // o
          3'd4:    b = 8'h74; // t
          default: b = ChSemi;
        endcase
      end
      KIND_APOS: begin
        case (idx)
          3'd0:    b = ChAmp;
          3'd1:    b = ChHash;
          3'd2:    b = 8'h30; // 0
          3'd3:    b = 8'h33; // 3
          3'd4:    b = 8'h39; // 9
          default: b = ChSemi;
        endcase
      end
      KIND_LT: begin
        case (idx)
          3'd0:    b = ChAmp;
          3'd1:    b = 8'h6c; // l
          3'd2:    b = 8'h74; // t
          default: b = ChSemi;
        endcase
      end
      KIND_GT: begin
        case (idx)
          3'd0:    b = ChAmp;
          3'd1:    b = 8'h67; // g
          3'd2:    b = 8'h74; // t
          default: b = ChSemi;
        endcase
      end
      default: b = raw;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/hee_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hee_ifs: stream channels of the HTML entity escaper
// Input byte channel and output byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hee_in_if;
  logic                      valid;
  logic                      ready;
  logic [hee_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hee_out_if;
  logic                      valid;
  logic                      ready;
  logic [hee_pkg::ByteW-1:0] out_byte;
  logic                      out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> rtl/html_entity_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_entity_escaper: HTML special character escaper
// Replaces enabled &, ", ', <, > with their entities; other bytes pass through.
// ----------------------------------------------------------------------------
// Path: input item -> queue entry -> back-end output register.
// Throughput: one output byte per cycle while out_o is ready, so plain bytes
//   flow at one item per cycle; an entity of 4 to 6 bytes holds the expander
//   until its last byte is out and the two-entry queue then stalls input.
// Reset: escape mask returns to 5'd31 (all escapes on), queue and output empty.
module html_entity_escaper (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hee_pkg::MaskW-1:0] cfg_wdata_i,
  hee_in_if.sink                    in_i,
  hee_out_if.source                 out_o
);

  logic           push_valid, push_ready;
  hee_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  hee_pkg::item_t pop_item;

  hee_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  hee_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  hee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

>>> rtl/hee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hee_front: input side of the escaper
// Holds the enable mask, classifies each byte and pushes it into the queue.
// ----------------------------------------------------------------------------
module hee_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hee_pkg::MaskW-1:0] cfg_wdata_i,
  hee_in_if.sink                    in_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output hee_pkg::item_t            push_item_o
);

  logic [hee_pkg::MaskW-1:0] mask_q, mask_d;
  hee_pkg::ent_kind_e        kind;

  always_comb begin
    mask_d = cfg_we_i ? cfg_wdata_i : mask_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= hee_pkg::MaskReset;
    end else begin
      mask_q <= mask_d;
    end
  end

  // disabled specials fall through as plain bytes
  always_comb begin
    kind = hee_pkg::KIND_PASS;
    case (in_i.in_byte)
      hee_pkg::ChAmp:  if (mask_q[hee_pkg::BitAmp])  kind = hee_pkg::KIND_AMP;
      hee_pkg::ChQuot: if (mask_q[hee_pkg::BitQuot]) kind = hee_pkg::KIND_QUOT;
      hee_pkg::ChApos: if (mask_q[hee_pkg::BitApos]) kind = hee_pkg::KIND_APOS;
      hee_pkg::ChLt:   if (mask_q[hee_pkg::BitLt])   kind = hee_pkg::KIND_LT;
      hee_pkg::ChGt:   if (mask_q[hee_pkg::BitGt])   kind = hee_pkg::KIND_GT;
      default:         kind = hee_pkg::KIND_PASS;
    endcase
  end

  assign push_valid_o     = in_i.valid;
  assign in_i.ready       = push_ready_i;
  assign push_item_o.kind = kind;
  assign push_item_o.raw  = in_i.in_byte;

endmodule

>>> rtl/hee_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hee_queue: short item queue between front and back
// Small register FIFO that lets the classifier and the expander stall apart.
// ----------------------------------------------------------------------------
module hee_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  hee_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output hee_pkg::item_t pop_item_o
);

  hee_pkg::item_t                mem_q [hee_pkg::QDepth];
  logic [hee_pkg::QAddrW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [hee_pkg::QCountW-1:0]   cnt_q, cnt_d;
  logic                          push, pop;

  assign push_ready_o = (cnt_q != hee_pkg::QCountW'(hee_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/hee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hee_back: output side of the escaper
// Steps through the entity of the head item, one byte per cycle while the
// output is ready, into an output register.
// ----------------------------------------------------------------------------
module hee_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  hee_pkg::item_t pop_item_i,
  hee_out_if.source      out_o
);

  logic [hee_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                      ovalid_q, ovalid_d;
  logic [hee_pkg::ByteW-1:0] obyte_q, obyte_d;
  logic                      olast_q, olast_d;
  logic [hee_pkg::IdxW-1:0]  len;
  logic                      slot_free, load, is_last;

  assign len       = hee_pkg::entity_len(pop_item_i.kind);
  assign is_last   = (idx_q == len - 1'b1);
  assign slot_free = !ovalid_q || out_o.ready;
  assign load      = slot_free && pop_valid_i;
  // release the head item together with its final byte
  assign pop_ready_o = slot_free && is_last;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    if (load) begin
      ovalid_d = 1'b1;
      obyte_d  = hee_pkg::entity_byte(pop_item_i.kind, idx_q, pop_item_i.raw);
      olast_d  = is_last;
      idx_d    = is_last ? '0 : idx_q + 1'b1;
    end else if (slot_free) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.out_last = olast_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_i |-> (idx_q < len))
    else $error("entity index beyond entity length");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_valid_i |-> (idx_q == '0))
    else $error("entity index not cleared with empty queue");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && is_last) |=> (idx_q == '0))
    else $error("entity index did not restart after final byte");

  a_pass_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && pop_item_i.kind == hee_pkg::KIND_PASS) |-> is_last)
    else $error("plain byte not emitted as a single last byte");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for html_entity_escaper
// Sends text bytes under several escape masks, expands each accepted byte into
// its expected output bytes and compares them in order with the output stream.
// Both sides idle at random; one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [hee_pkg::ByteW-1:0] data;
    logic                      last;
  } out_byte_t;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold  = 80;

  localparam logic [hee_pkg::ByteW-1:0] SpecialChars [5] = '{
    hee_pkg::ChAmp, hee_pkg::ChQuot, hee_pkg::ChApos, hee_pkg::ChLt, hee_pkg::ChGt
  };
  localparam logic [hee_pkg::ByteW-1:0] EdgeText [13] = '{
    8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, hee_pkg::ChAmp, hee_pkg::ChQuot,
    hee_pkg::ChApos, hee_pkg::ChLt, hee_pkg::ChGt, 8'h41, hee_pkg::ChSemi,
    hee_pkg::ChHash
  };
  localparam logic [hee_pkg::ByteW-1:0] MaskedText [7] = '{
    hee_pkg::ChAmp, hee_pkg::ChQuot, hee_pkg::ChApos, hee_pkg::ChLt, hee_pkg::ChGt,
    8'haa, 8'h55
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [hee_pkg::MaskW-1:0] cfg_wdata_i;

  hee_in_if  in_if ();
  hee_out_if out_if ();

  html_entity_escaper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  logic [hee_pkg::ByteW-1:0] text_q [$];   // bytes waiting to be sent
  out_byte_t                 entity_q [$]; // expected output bytes, oldest first
  logic [hee_pkg::MaskW-1:0] esc_mask;
  int                        errors = 0;
  bit                        tx_gaps_on;
  bit                        rx_stalls_on;
  int                        hold_req = 0;
  int                        hold_served = 0;
  int                        tx_gap;
  int                        rx_stall;
  int                        hold_cnt;
  int                        idle_cycles = 0;
  out_byte_t                 got_b;
  out_byte_t                 exp_b;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // expand one text byte under the current mask into its output bytes
  function automatic void escape_byte(input logic [hee_pkg::ByteW-1:0] b);
    string ent;
    ent = "";
    case (b)
      hee_pkg::ChAmp:  if (esc_mask[hee_pkg::BitAmp])  ent = "&amp;";
      hee_pkg::ChQuot: if (esc_mask[hee_pkg::BitQuot]) ent = "&quot;";
      hee_pkg::ChApos: if (esc_mask[hee_pkg::BitApos]) ent = "&#039;";
      hee_pkg::ChLt:   if (esc_mask[hee_pkg::BitLt])   ent = "&lt;";
      hee_pkg::ChGt:   if (esc_mask[hee_pkg::BitGt])   ent = "&gt;";
      default: ent = "";
    endcase
    if (ent.len() == 0) begin
      entity_q.push_back('{data: b, last: 1'b1});
    end else begin
      for (int i = 0; i < ent.len(); i++)
        entity_q.push_back('{data: ent[i], last: (i == ent.len() - 1)});
    end
  endfunction

  function automatic logic [hee_pkg::ByteW-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return SpecialChars[$urandom_range(0, 4)];
    if (r < 65) return hee_pkg::ByteW'($urandom_range(8'h20, 8'h7e));
    return hee_pkg::ByteW'($urandom_range(0, 255));
  endfunction

  // sender: take the next pending byte once the current one is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= '0;
      tx_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) escape_byte(in_if.in_byte);
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= text_q.pop_front();
          tx_gap = tx_gaps_on ? gap_len() : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each output byte against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_stall = 0;
      hold_cnt = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_b = '{data: out_if.out_byte, last: out_if.out_last};
        if (entity_q.size() == 0) begin
          $display("%0t: unexpected output byte %h last %b", $time, got_b.data, got_b.last);
          errors++;
        end else begin
          exp_b = entity_q.pop_front();
          if (got_b.data !== exp_b.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, exp_b.data, got_b.data);
            errors++;
          end
          if (got_b.last !== exp_b.last) begin
            $display("%0t: out_last expected %b actual %b", $time, exp_b.last, got_b.last);
            errors++;
          end
        end
      end
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        hold_cnt = LongHold;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) rx_stall = gap_len();
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_mask(input logic [hee_pkg::MaskW-1:0] m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    esc_mask = m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold until every sent byte has been expanded and checked
  task automatic drain();
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_if.valid || entity_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    @(negedge clk_i);
    for (int i = 0; i < count; i++) text_q.push_back(pick_byte());
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    esc_mask      = hee_pkg::MaskReset;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes and every entity under the reset mask
    @(negedge clk_i);
    foreach (EdgeText[i]) text_q.push_back(EdgeText[i]);
    drain();

    // all escapes off: specials pass through
    write_mask('0);
    @(negedge clk_i);
    foreach (MaskedText[i]) text_q.push_back(MaskedText[i]);
    drain();

    // long output hold-off while the sender keeps offering entities
    write_mask(5'h1f);
    tx_gaps_on = 1'b0;
    @(negedge clk_i);
    for (int i = 0; i < 20; i++) text_q.push_back(SpecialChars[$urandom_range(0, 4)]);
    do @(negedge clk_i); while (!in_if.valid);
    hold_req++;
    drain();

    // random text, idling on both sides but in the first two runs, each with one side steady
    send_random(30);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b0;
    write_mask(5'h15);
    send_random(30);
    rx_stalls_on = 1'b1;
    write_mask(5'h0a);
    send_random(30);
    write_mask(hee_pkg::MaskW'($urandom_range(0, 31)));
    send_random(30);
    write_mask('0);
    send_random(25);
    write_mask(hee_pkg::MaskW'($urandom_range(0, 31)));
    send_random(30);

    repeat (20) @(negedge clk_i);
    if (errors == 0 && entity_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> html_entity_escaper.f
rtl/hee_pkg.sv
rtl/hee_ifs.sv
rtl/hee_front.sv
rtl/hee_queue.sv
rtl/hee_back.sv
rtl/html_entity_escaper.sv
tb/testbench.sv
